@@ sv/lcgs_pkg.sv @@
package lcgs_pkg;

   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int COL_W       = $clog2(GRID_WIDTH);
   localparam int ROW_W       = $clog2(GRID_HEIGHT);
   localparam int POS_W       = 8;
   localparam int RND_W       = 16;
   localparam int LINE_W      = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_STEPS   = RND_W;
   localparam int STEP_W      = $clog2(DIV_STEPS + 1);
   localparam int NCOUNT_W    = 4;

   localparam logic [NCOUNT_W-1:0] BIRTH_COUNT = NCOUNT_W'(3);
   localparam logic [NCOUNT_W-1:0] SURVIVE_LOW = NCOUNT_W'(2);

   typedef enum logic [1:0] {
      KIND_DEAD     = 2'd0,
      KIND_SURVIVOR = 2'd1,
      KIND_BORN     = 2'd2
   } kind_type;

   typedef enum logic {
      B_IDLE,
      B_DIV
   } back_state_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             survive;
      logic             birth;
      logic [RND_W-1:0] rnd;
      logic             last;
   } entry_type;

endpackage

@@ sv/lcgs_ram.sv @@
module lcgs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/lcgs_front.sv @@
module lcgs_front import lcgs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_cell_alive,
   input  logic [RND_W-1:0] req_random_value,
   output logic             push_valid,
   output entry_type        push_data,
   input  logic             queue_full,
   output logic             ram_rd_en,
   output logic [COL_W-1:0] ram_rd_addr,
   input  logic [LINE_W-1:0] ram_rd_data,
   output logic             ram_wr_en,
   output logic [COL_W-1:0] ram_wr_addr,
   output logic [LINE_W-1:0] ram_wr_data
);
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             pend_ff, pend_in;
   logic [ROW_W-1:0] p_row_ff;
   logic [COL_W-1:0] p_col_ff;
   logic             p_cur_ff;
   logic [RND_W-1:0] p_rnd_ff;
   logic [8:0]       win_ff, win_in;
   logic             accept, produce, retire, border;
   logic             up, mid;
   logic [NCOUNT_W-1:0] ncount;
   logic [ROW_W-1:0] row_m1;
   logic [COL_W-1:0] col_m1;

   assign accept  = req_valid && req_ready;
   assign produce = (p_row_ff >= ROW_W'(2)) && (p_col_ff >= COL_W'(2));
   assign retire  = pend_ff && (!produce || !queue_full);
   assign req_ready = !pend_ff || retire;
   assign border  = (row_ff == '0) || (row_ff == ROW_W'(GRID_HEIGHT - 1)) ||
                    (col_ff == '0) || (col_ff == COL_W'(GRID_WIDTH - 1));

   // line memory bit 0 is the middle row, bit 1 the upper row
   assign mid = ram_rd_data[0];
   assign up  = ram_rd_data[1];
   assign ram_rd_en   = accept;
   assign ram_rd_addr = col_ff;
   assign ram_wr_en   = retire;
   assign ram_wr_addr = p_col_ff;
   assign ram_wr_data = {mid, p_cur_ff};

   always_comb begin
      win_in = {win_ff[5:0], p_cur_ff, mid, up};
      ncount = '0;
      for (int i = 0; i < 9; i++) begin
         ncount = ncount + NCOUNT_W'(win_in[i]);
      end
      ncount = ncount - NCOUNT_W'(win_in[4]);
   end

   assign row_m1 = p_row_ff - ROW_W'(1);
   assign col_m1 = p_col_ff - COL_W'(1);
   assign push_valid        = retire && produce;
   assign push_data.row     = POS_W'(row_m1);
   assign push_data.col     = POS_W'(col_m1);
   assign push_data.survive = win_in[4] && (ncount == SURVIVE_LOW || ncount == BIRTH_COUNT);
   assign push_data.birth   = (ncount == BIRTH_COUNT);
   assign push_data.rnd     = p_rnd_ff;
   assign push_data.last    = (p_row_ff == ROW_W'(GRID_HEIGHT - 1)) &&
                              (p_col_ff == COL_W'(GRID_WIDTH - 1));

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      pend_in = pend_ff;
      if (retire) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         pend_in = 1'b1;
         if (col_ff == COL_W'(GRID_WIDTH - 1)) begin
            col_in = '0;
            row_in = (row_ff == ROW_W'(GRID_HEIGHT - 1)) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         pend_ff <= 1'b0;
         win_ff  <= '0;
      end else begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         pend_ff <= pend_in;
         if (retire) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_row_ff <= row_ff;
         p_col_ff <= col_ff;
         p_cur_ff <= req_cell_alive && !border;
         p_rnd_ff <= req_random_value;
      end
   end
endmodule

@@ sv/lcgs_queue.sv @@
module lcgs_queue import lcgs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type head,
   output logic      full,
   output logic      empty
);
   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + QCNT_W'(1);
         2'b01:   cnt_in = cnt_ff - QCNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

@@ sv/lcgs_back.sv @@
module lcgs_back import lcgs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  entry_type        head,
   output logic             pop,
   input  logic [RND_W-1:0] divisor,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [POS_W-1:0] rsp_cell_row,
   output logic [POS_W-1:0] rsp_cell_col,
   output logic             rsp_next_alive,
   output logic [1:0]       rsp_cell_kind,
   output logic             rsp_frame_last
);
   back_state_type    state_ff, state_in;
   entry_type         ent_ff, ent_in;
   logic [RND_W:0]    rem_ff, rem_in;
   logic [RND_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   entry_type         out_ent_ff, out_ent_in;
   kind_type          kind_ff, kind_in;
   logic              slot_free;
   logic [RND_W:0]    trial;

   assign slot_free = !valid_ff || rsp_ready;
   assign trial     = {rem_ff[RND_W-1:0], quo_ff[RND_W-1]};

   always_comb begin
      state_in   = state_ff;
      ent_in     = ent_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      valid_in   = valid_ff && !rsp_ready;
      out_ent_in = out_ent_ff;
      kind_in    = kind_ff;
      pop        = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty && slot_free) begin
               pop = 1'b1;
               priority if (head.survive) begin
                  valid_in = 1'b1; out_ent_in = head; kind_in = KIND_SURVIVOR;
               end else if (head.birth) begin
                  valid_in = 1'b1; out_ent_in = head; kind_in = KIND_BORN;
               end else if (divisor == '0) begin
                  valid_in = 1'b1; out_ent_in = head; kind_in = KIND_DEAD;
               end else begin
                  ent_in   = head;
                  rem_in   = '0;
                  quo_in   = head.rnd;
                  step_in  = '0;
                  state_in = B_DIV;
               end
            end
         end
         B_DIV: begin
            if (step_ff != STEP_W'(DIV_STEPS)) begin
               // one restoring remainder step
               rem_in  = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
               quo_in  = {quo_ff[RND_W-2:0], 1'b0};
               step_in = step_ff + STEP_W'(1);
            end else if (slot_free) begin
               valid_in   = 1'b1;
               out_ent_in = ent_ff;
               kind_in    = (rem_ff == '0) ? KIND_BORN : KIND_DEAD;
               state_in   = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff     <= ent_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      out_ent_ff <= out_ent_in;
      kind_ff    <= kind_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_cell_row   = out_ent_ff.row;
   assign rsp_cell_col   = out_ent_ff.col;
   assign rsp_next_alive = (kind_ff != KIND_DEAD);
   assign rsp_cell_kind  = kind_ff;
   assign rsp_frame_last = out_ent_ff.last;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> divisor != '0) else $error("spawn divide with zero divisor");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty) else $error("pop from empty queue");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> step_ff <= STEP_W'(DIV_STEPS)) else $error("step overrun");
   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (kind_ff == KIND_DEAD || kind_ff == KIND_SURVIVOR || kind_ff == KIND_BORN))
      else $error("bad result kind");
endmodule

@@ sv/life_cell_generation_stencil_core.sv @@
// life generation stencil, b3/s23 rule with optional random spawn
// request channel: one cell per request in raster order (row by row, column 0
//   first) with its alive bit and a 16-bit random draw
// response channel: next state of an interior cell, emitted once the cell
//   below and right of it has arrived; border cells never get a response
// csr port: spawn divisor, written while idle; zero turns random births off
// path: survivors, births by count and deaths with spawn off go from the queue
//   straight to the response register; a cell that needs the spawn test first
//   runs through the iterative remainder unit
// throughput: one request per cycle while the queue has room, set by the line memory
//   read; a cell needing the spawn test holds the back end in the iterative
//   remainder unit, during which a 4-deep queue absorbs further cells
// reset clears the raster position, window and queue; line memory contents
//   need no clearing since rows 0 and 1 rewrite them before any response
// a stalled response receiver holds the output register, fills the queue and
//   then drops req_ready
module life_cell_generation_stencil_core import lcgs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_cell_alive,
   input  logic [RND_W-1:0] req_random_value,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [POS_W-1:0] rsp_cell_row,
   output logic [POS_W-1:0] rsp_cell_col,
   output logic             rsp_next_alive,
   output logic [1:0]       rsp_cell_kind,
   output logic             rsp_frame_last,
   input  logic             csr_wr_en,
   input  logic [RND_W-1:0] csr_wr_data
);
   // spawn divisor register
   logic [RND_W-1:0] divisor_ff;

   // line memory and queue hookup
   logic              push_valid, queue_full, q_empty, pop;
   entry_type         push_data, head;
   logic              ram_rd_en, ram_wr_en;
   logic [COL_W-1:0]  ram_rd_addr, ram_wr_addr;
   logic [LINE_W-1:0] ram_rd_data, ram_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff <= '0;
      end else if (csr_wr_en) begin
         divisor_ff <= csr_wr_data;
      end
   end

   // two rows above the current one, one bit each per column
   lcgs_ram #(.WIDTH(LINE_W), .DEPTH(GRID_WIDTH)) u_line (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // front: position tracking, window, neighbour count and rule classification
   lcgs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cell_alive   (req_cell_alive),
      .req_random_value (req_random_value),
      .push_valid       (push_valid),
      .push_data        (push_data),
      .queue_full       (queue_full),
      .ram_rd_en        (ram_rd_en),
      .ram_rd_addr      (ram_rd_addr),
      .ram_rd_data      (ram_rd_data),
      .ram_wr_en        (ram_wr_en),
      .ram_wr_addr      (ram_wr_addr),
      .ram_wr_data      (ram_wr_data)
   );

   // decouples the front (one cell per cycle unless the queue fills) from the slow spawn test
   lcgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (queue_full),
      .empty     (q_empty)
   );

   // back: spawn remainder test and response register
   lcgs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .head           (head),
      .pop            (pop),
      .divisor        (divisor_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cell_row   (rsp_cell_row),
      .rsp_cell_col   (rsp_cell_col),
      .rsp_next_alive (rsp_next_alive),
      .rsp_cell_kind  (rsp_cell_kind),
      .rsp_frame_last (rsp_frame_last)
   );
endmodule

@@ test/life_cell_generation_stencil_checker.sv @@
`timescale 1ns / 1ps

module life_cell_generation_stencil_checker import lcgs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic             req_cell_alive,
   input  logic [RND_W-1:0] req_random_value,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [POS_W-1:0] rsp_cell_row,
   input  logic [POS_W-1:0] rsp_cell_col,
   input  logic             rsp_next_alive,
   input  logic [1:0]       rsp_cell_kind,
   input  logic             rsp_frame_last,
   input  logic             csr_wr_en,
   input  logic [RND_W-1:0] csr_wr_data,
   output int               fail_count,
   output int               pending_count
);

   typedef struct {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             alive;
      kind_type         kind;
      logic             last;
   } next_cell_type;

   next_cell_type    next_cells[$];
   logic             row_above[GRID_WIDTH];
   logic             row_middle[GRID_WIDTH];
   logic [8:0]       window;
   int               cur_row;
   int               cur_col;
   logic [RND_W-1:0] divisor;

   assign pending_count = next_cells.size();

   task automatic compute_next(input logic alive_in, input logic [RND_W-1:0] rnd);
      logic          cur;
      logic          up;
      logic          mid;
      int            n;
      next_cell_type e;
      cur = alive_in;
      if (cur_row == 0 || cur_row == GRID_HEIGHT - 1 || cur_col == 0 ||
          cur_col == GRID_WIDTH - 1)
         cur = 1'b0;
      up = row_above[cur_col];
      mid = row_middle[cur_col];
      row_above[cur_col] = mid;
      row_middle[cur_col] = cur;
      window = {window[5:0], cur, mid, up};
      if (cur_row >= 2 && cur_col >= 2) begin
         n = $countones(window) - int'(window[4]);
         e.row = POS_W'(cur_row - 1);
         e.col = POS_W'(cur_col - 1);
         if (window[4] && (n == 2 || n == 3)) begin
            e.alive = 1'b1;
            e.kind = KIND_SURVIVOR;
         end else if (n == 3 || (divisor != 0 && rnd % divisor == 0)) begin
            e.alive = 1'b1;
            e.kind = KIND_BORN;
         end else begin
            e.alive = 1'b0;
            e.kind = KIND_DEAD;
         end
         e.last = (cur_row == GRID_HEIGHT - 1 && cur_col == GRID_WIDTH - 1);
         next_cells.push_back(e);
      end
      if (cur_col == GRID_WIDTH - 1) begin
         cur_col = 0;
         cur_row = (cur_row == GRID_HEIGHT - 1) ? 0 : cur_row + 1;
      end else begin
         cur_col = cur_col + 1;
      end
   endtask

   always @(posedge clock) begin
      next_cell_type e;
      if (reset) begin
         next_cells.delete();
         for (int i = 0; i < GRID_WIDTH; i++) begin
            row_above[i] = 1'b0;
            row_middle[i] = 1'b0;
         end
         window = '0;
         cur_row = 0;
         cur_col = 0;
         divisor = '0;
         fail_count = 0;
      end else begin
         if (csr_wr_en)
            divisor = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (next_cells.size() == 0) begin
               $display("%0t unexpected response row %0d col %0d", $time, rsp_cell_row,
                        rsp_cell_col);
               fail_count++;
            end else begin
               e = next_cells.pop_front();
               if (rsp_cell_row !== e.row || rsp_cell_col !== e.col ||
                   rsp_next_alive !== e.alive || rsp_cell_kind !== e.kind ||
                   rsp_frame_last !== e.last) begin
                  $display("%0t mismatch expected row %0d col %0d alive %0d kind %0d last %0d",
                           $time, e.row, e.col, e.alive, e.kind, e.last);
                  $display("%0t            actual row %0d col %0d alive %0d kind %0d last %0d",
                           $time, rsp_cell_row, rsp_cell_col, rsp_next_alive,
                           rsp_cell_kind, rsp_frame_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            compute_next(req_cell_alive, req_random_value);
      end
   end

endmodule

@@ test/tb_life_cell_generation_stencil_core.sv @@
`timescale 1ns / 1ps

module tb_life_cell_generation_stencil_core;
   import lcgs_pkg::*;

   // two full rows plus part of the first row that yields responses
   localparam int CELL_TARGET = 2 * GRID_WIDTH + 48;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_WAIT  = 40;
   localparam int SEG_LEN     = 12;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_cell_alive;
   logic [RND_W-1:0] req_random_value;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [POS_W-1:0] rsp_cell_row;
   logic [POS_W-1:0] rsp_cell_col;
   logic             rsp_next_alive;
   logic [1:0]       rsp_cell_kind;
   logic             rsp_frame_last;
   logic             csr_wr_en;
   logic [RND_W-1:0] csr_wr_data;
   int               fail_count;
   int               pending_count;
   int               req_idle_pct;
   int               rsp_stall_pct;
   int               cycle_count = 0;
   int               cells_sent;
   logic [RND_W-1:0] spawn_div;

   life_cell_generation_stencil_core i_dut (.*);

   life_cell_generation_stencil_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver backpressure, percentage set per phase
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one cell request, with random sender gaps before it
   task automatic send_cell(input logic alive, input logic [RND_W-1:0] rnd);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell_alive <= alive;
      req_random_value <= rnd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cells_sent++;
   endtask

   // divisor only changes once everything in flight has drained
   task automatic write_divisor(input logic [RND_W-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      spawn_div = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // random draw biased to extremes and to multiples of the divisor
   function automatic logic [RND_W-1:0] pick_random();
      int sel;
      sel = $urandom_range(99);
      if (sel < 15) return '0;
      if (sel < 25) return '1;
      if (sel < 45 && spawn_div != 0) return RND_W'(spawn_div * $urandom_range(3));
      return RND_W'($urandom);
   endfunction

   initial begin
      int seg;
      int density;
      reset = 1'b1;
      req_valid = 1'b0;
      req_cell_alive = 1'b0;
      req_random_value = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      cells_sent = 0;
      spawn_div = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: live border cells and extreme draws, all in row 0
      write_divisor('1);
      for (int i = 0; i < 20; i++)
         send_cell(i[0], i[1] ? '1 : '0);

      seg = 0;
      while (cells_sent < CELL_TARGET) begin
         // idle phases: none, sender gaps, receiver stalls, both
         case (seg % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 51; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 51; end
            default: begin req_idle_pct = 19; rsp_stall_pct = 19; end
         endcase
         // short segments so every phase meets responding cells and divisors change often
         case (seg % 6)
            1: write_divisor(16'd1);
            3: write_divisor('1);
            4: write_divisor(RND_W'($urandom_range(2, 7)));
            5: write_divisor(RND_W'($urandom_range(1, 65535)));
            default: write_divisor('0);
         endcase
         case ($urandom_range(3))
            0: density = 10;
            1: density = 35;
            2: density = 50;
            default: density = 90;
         endcase
         for (int i = 0; i < SEG_LEN && cells_sent < CELL_TARGET; i++)
            send_cell($urandom_range(99) < density, pick_random());
         seg++;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
